@@ rtl/ddsr_pkg.sv @@
// Shared types and constants for the decimal digit shift and rotate register.
package ddsr_pkg;

  // Storage geometry.
  localparam int MaxDigits = 16;
  localparam int PosW      = $clog2(MaxDigits);
  localparam int LenW      = $clog2(MaxDigits + 1);

  // Field types.
  typedef logic [3:0]      digit_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [2:0]      opcode_t;
  typedef logic [7:0]      amount_t;

  // Largest legal decimal digit.
  localparam digit_t DigitTop = 4'd9;

  // Operation codes.
  localparam opcode_t OpLoad   = 3'd0;
  localparam opcode_t OpCompl  = 3'd1;
  localparam opcode_t OpRev    = 3'd2;
  localparam opcode_t OpShr    = 3'd3;
  localparam opcode_t OpRotr   = 3'd4;
  localparam opcode_t OpShl    = 3'd5;
  localparam opcode_t OpRotl   = 3'd6;
  localparam opcode_t OpNone   = 3'd7;

endpackage

@@ rtl/ddsr_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface ddsr_in_if;
  logic              valid;
  logic              ready;
  ddsr_pkg::opcode_t opcode;
  ddsr_pkg::pos_t    position;
  ddsr_pkg::digit_t  digit_in;
  ddsr_pkg::amount_t shift_amount;

  modport source (output valid, output opcode, output position, output digit_in,
                  output shift_amount, input ready);
  modport sink (input valid, input opcode, input position, input digit_in,
                input shift_amount, output ready);
endinterface

interface ddsr_out_if;
  logic             valid;
  logic             ready;
  ddsr_pkg::digit_t digit_out;
  ddsr_pkg::pos_t   out_position;
  logic             last;
  logic             status;

  modport source (output valid, output digit_out, output out_position, output last,
                  output status, input ready);
  modport sink (input valid, input digit_out, input out_position, input last,
                input status, output ready);
endinterface

@@ rtl/ddsr_mod.sv @@
// Bit-serial remainder unit: shift amount modulo the active length, one bit per cycle.
module ddsr_mod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ddsr_pkg::amount_t dividend,
  input  ddsr_pkg::len_t    divisor,
  output logic              done,
  output ddsr_pkg::digit_t  rem
);
  import ddsr_pkg::*;

  localparam int AmtW = $bits(amount_t);
  localparam int CntW = $clog2(AmtW);

  logic                    busy;
  logic [CntW-1:0]         cnt;
  amount_t                 dvd;
  len_t                    dsr;
  logic [4:0]              trial;
  logic [4:0]              diff;

  // Bring down the next dividend bit and try one subtraction.
  assign trial = {rem, dvd[AmtW-1]};
  assign diff  = trial - dsr;

  // Control: step once per dividend bit, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CntW'(AmtW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(AmtW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: restoring remainder, the remainder stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[AmtW-2:0], 1'b0};
      if (trial >= dsr) begin
        rem <= diff[3:0];
      end else begin
        rem <= trial[3:0];
      end
    end
  end

  // The finished remainder is always smaller than the divisor.
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < dsr))
    else $error("remainder not below divisor");

endmodule

@@ rtl/decimal_digit_shift_rotate_register.sv @@
// Decimal digit shift and rotate register: top level with sequencer and digit store.
//
// Usage: input items arrive on in_ch (opcode, position, digit_in, shift_amount) and
// result items leave on out_ch (digit_out, out_position, last, status), both with a
// valid/ready handshake. The user must write the active length through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce
// this. A length of 0 acts as 1 and one above 16 acts as 16. A load item gives one
// result item with last set; a digit above 9 is refused with status 1. Opcode 7
// gives no result. Every other operation walks the active digits one per cycle
// through a single read port of the store, reports each new digit with its
// position, and marks the final one with last. A load result is offered in the
// cycle after the load is taken, and loads can follow one per cycle while the
// receiver is ready. Rotates first run the bit-serial remainder unit on the shift
// amount. In the digit walk one digit is read, transformed and sent per cycle.
// Reset clears the store to zeros and sets the length to 16.
// When the receiver stalls, the output register holds its item and the walk pauses;
// a new input item is taken only after the previous one has produced all its results.
module decimal_digit_shift_rotate_register (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [4:0]       cfg_wr_data,
  ddsr_in_if.sink          in_ch,
  ddsr_out_if.source       out_ch
);
  import ddsr_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MOD    = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [4:0] len_reg;
  len_t       n_eff;
  len_t       n_cur;
  pos_t       nm1;
  opcode_t    op_cur;
  amount_t    k_cur;
  pos_t       idx;
  pos_t       src;
  digit_t     store [MaxDigits];
  digit_t     shadow [MaxDigits];

  logic       out_valid;
  digit_t     out_digit;
  pos_t       out_pos;
  logic       out_last;
  logic       out_status;
  logic       out_free;
  logic       accept;
  logic       mod_start;
  logic       mod_done;
  digit_t     mod_rem;

  logic       k_lt_n;
  logic [8:0] shl_sum;
  pos_t       rd_addr;
  logic       fill_zero;
  digit_t     rd_digit;
  digit_t     new_digit;
  logic       step;
  logic       run_last;

  // Effective length, clamped to 1..MaxDigits.
  always_comb begin
    if (len_reg == '0) begin
      n_eff = len_t'(1);
    end else if ({1'b0, len_reg} > 6'(MaxDigits)) begin
      n_eff = len_t'(MaxDigits);
    end else begin
      n_eff = len_t'(len_reg);
    end
  end

  assign nm1      = pos_t'(n_cur - 1'b1);
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign mod_start = accept && ((in_ch.opcode == OpRotr) || (in_ch.opcode == OpRotl));

  ddsr_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (in_ch.shift_amount),
    .divisor  (n_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Source position and zero fill for the digit produced this cycle.
  assign k_lt_n  = k_cur < {3'b0, n_cur};
  assign shl_sum = {5'b0, idx} + {1'b0, k_cur};
  always_comb begin
    rd_addr   = src;
    fill_zero = 1'b0;
    case (op_cur)
      OpShr: begin
        rd_addr   = idx - k_cur[PosW-1:0];
        fill_zero = !(k_lt_n && ({4'b0, idx} >= k_cur));
      end
      OpShl: begin
        rd_addr   = idx + k_cur[PosW-1:0];
        fill_zero = !(k_lt_n && (shl_sum < {4'b0, n_cur}));
      end
      default: begin
        rd_addr   = src;
        fill_zero = 1'b0;
      end
    endcase
  end

  // One store read per cycle, then complement or zero fill.
  assign rd_digit = store[rd_addr];
  always_comb begin
    if (fill_zero) begin
      new_digit = '0;
    end else if (op_cur == OpCompl) begin
      new_digit = DigitTop - rd_digit;
    end else begin
      new_digit = rd_digit;
    end
  end

  assign step     = (state == S_RUN) && out_free;
  assign run_last = idx == nm1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= 5'(MaxDigits);
    end else if (cfg_wr_en) begin
      len_reg <= cfg_wr_data;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (in_ch.opcode != OpLoad) && (in_ch.opcode != OpNone)) begin
            state <= mod_start ? S_MOD : S_RUN;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (step && run_last) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operation context and walk counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cur <= in_ch.opcode;
      k_cur  <= in_ch.shift_amount;
      n_cur  <= n_eff;
      idx    <= '0;
      if (in_ch.opcode == OpRev) begin
        src <= pos_t'(n_eff - 1'b1);
      end else begin
        src <= '0;
      end
    end else if ((state == S_MOD) && mod_done) begin
      if (op_cur == OpRotl) begin
        src <= mod_rem;
      end else if (mod_rem == '0) begin
        src <= '0;
      end else begin
        src <= pos_t'(n_cur - {1'b0, mod_rem});
      end
    end else if (step) begin
      idx <= idx + 1'b1;
      if (op_cur == OpRev) begin
        src <= src - 1'b1;
      end else if (src == nm1) begin
        src <= '0;
      end else begin
        src <= src + 1'b1;
      end
    end
  end

  // Digit store: loads write directly, operations copy the shadow back at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MaxDigits; j++) begin
        store[j] <= '0;
      end
    end else if (accept && (in_ch.opcode == OpLoad) && (in_ch.digit_in <= DigitTop)) begin
      store[in_ch.position] <= in_ch.digit_in;
    end else if (state == S_COMMIT) begin
      for (int j = 0; j < MaxDigits; j++) begin
        if (len_t'(j) < n_cur) begin
          store[j] <= shadow[j];
        end
      end
    end
  end

  // Shadow row collects the new digits as they are reported.
  always_ff @(posedge clk) begin
    if (step) begin
      shadow[idx] <= new_digit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (in_ch.opcode == OpLoad)) begin
      out_valid <= 1'b1;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_ch.opcode == OpLoad)) begin
      out_digit  <= '0;
      out_pos    <= in_ch.position;
      out_last   <= 1'b1;
      out_status <= in_ch.digit_in > DigitTop;
    end else if (step) begin
      out_digit  <= new_digit;
      out_pos    <= idx;
      out_last   <= run_last;
      out_status <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.digit_out    = out_digit;
  assign out_ch.out_position = out_pos;
  assign out_ch.last         = out_last;
  assign out_ch.status       = out_status;

  // A refused load is always a single, final result.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status) |-> out_last)
    else $error("refused load result without last mark");

  // The walk never runs past the active length.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ({1'b0, idx} < n_cur))
    else $error("digit walk beyond active length");

  // Write-back follows directly on the final reported digit.
  a_commit_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (out_valid && out_last))
    else $error("commit without final result pending");

endmodule
